@@ rtl/cfd_pkg.sv @@
// cfd_pkg: types, codes and the crc-16 ccitt byte step shared by the deframer
// no dependencies; compiled first

package cfd_pkg;

  localparam int CFD_MAX_PAYLOAD = 1024;
  localparam int HDR_BYTES       = 12;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [10:0] COUNT_SAT = 11'h7FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC     = 2'd0,
    CFG_VERSION   = 2'd1,
    CFG_CRC_START = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    VERDICT_OK          = 3'd0,
    VERDICT_TOO_SHORT   = 3'd1,
    VERDICT_BAD_MAGIC   = 3'd2,
    VERDICT_BAD_VERSION = 3'd3,
    VERDICT_TOO_LONG    = 3'd4,
    VERDICT_BAD_CRC     = 3'd5
  } verdict_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  version_byte;
    logic [15:0] crc_start;
  } cfg_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    verdict_t    verdict;
    logic [7:0]  frame_kind;
    logic [31:0] sequence_number;
    logic [10:0] payload_count;
    logic [15:0] received_crc;
  } result_t;

  typedef struct packed {
    logic frame_clear;
    logic verdict_given;
  } parser_status_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ rtl/cfd_if.sv @@
// cfd_rx_if / cfd_tx_if: valid-ready channels of the deframer
// depends on cfd_pkg

interface cfd_rx_if;
  import cfd_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface cfd_tx_if;
  import cfd_pkg::*;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  verdict;
  logic [7:0]  frame_kind;
  logic [31:0] sequence_number;
  logic [10:0] payload_count;
  logic [15:0] received_crc;

  modport source (output valid, output item_kind, output payload_byte, output verdict,
                  output frame_kind, output sequence_number, output payload_count,
                  output received_crc, input ready);
  modport sink   (input valid, input item_kind, input payload_byte, input verdict,
                  input frame_kind, input sequence_number, input payload_count,
                  input received_crc, output ready);
endinterface

@@ rtl/crc16_frame_deframer.sv @@
// crc16_frame_deframer: top level, config registers, parser and result buffer
// depends on cfd_pkg, cfd_if, cfd_parser and cfd_skid
//
//   channel  dir  payload                                  request moved when
//   rx_ch    in   rx_byte, buffer_end                      valid && ready
//   tx_ch    out  item_kind, payload_byte, verdict,        valid && ready
//                 frame_kind, sequence_number,
//                 payload_count, received_crc
//   cfg      in   cfg_we, cfg_index, cfg_data              cfg_we
//
// one byte per cycle while rx ready; results are registered in the result buffer
// the crc step and header compare sit between the frame state and the result stage
// a two-entry result buffer lets rx take one more result while tx is stalled
// rx ready drops only while both result entries are full
// sync reset clears frame state, result valids and config, crc seeds to ffff

module crc16_frame_deframer #(
  parameter int MAX_PAYLOAD = cfd_pkg::CFD_MAX_PAYLOAD
) (
  input  logic                            clk,
  input  logic                            rst,
  cfd_rx_if.sink                          rx_ch,
  cfd_tx_if.source                        tx_ch,
  input  logic                            cfg_we,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cfd_pkg::*;

  cfg_t           cfg;
  logic           accept;
  logic           res_valid;
  result_t        res;
  result_t        tx_data;
  parser_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word   <= '0;
      cfg.version_byte <= '0;
      cfg.crc_start    <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MAGIC:     cfg.magic_word   <= cfg_data;
        CFG_VERSION:   cfg.version_byte <= cfg_data[7:0];
        CFG_CRC_START: cfg.crc_start    <= cfg_data[15:0];
        default:       ;
      endcase
    end
  end

  assign accept = rx_ch.valid && rx_ch.ready;

  cfd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .rx_byte   (rx_ch.rx_byte),
    .buffer_end(rx_ch.buffer_end),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  cfd_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept && res_valid),
    .in_ready (rx_ch.ready),
    .in_data  (res),
    .out_valid(tx_ch.valid),
    .out_ready(tx_ch.ready),
    .out_data (tx_data)
  );

  assign tx_ch.item_kind       = tx_data.item_kind;
  assign tx_ch.payload_byte    = tx_data.payload_byte;
  assign tx_ch.verdict         = tx_data.verdict;
  assign tx_ch.frame_kind      = tx_data.frame_kind;
  assign tx_ch.sequence_number = tx_data.sequence_number;
  assign tx_ch.payload_count   = tx_data.payload_count;
  assign tx_ch.received_crc    = tx_data.received_crc;

`ifndef SYNTHESIS
  a_ready_low_means_full: assert property (@(posedge clk) disable iff (rst)
    !rx_ch.ready |-> tx_ch.valid)
    else $error("rx stalled with an empty output stage");

  a_end_clears_frame: assert property (@(posedge clk) disable iff (rst)
    accept && rx_ch.buffer_end |=> status.frame_clear)
    else $error("frame state not cleared after buffer end");

  a_payload_item_clean: assert property (@(posedge clk) disable iff (rst)
    tx_ch.valid && (tx_ch.item_kind == KIND_PAYLOAD) |->
      (tx_ch.verdict == VERDICT_OK) && (tx_ch.payload_count == '0))
    else $error("payload item carries verdict fields");

  a_no_item_after_verdict: assert property (@(posedge clk) disable iff (rst)
    accept && status.verdict_given |=> !(tx_ch.valid && !$past(tx_ch.valid)))
    else $error("result produced after the frame verdict");
`endif

endmodule

@@ rtl/cfd_parser.sv @@
// cfd_parser: per-byte frame state, header capture, crc update and result build
// depends on cfd_pkg

module cfd_parser #(
  parameter int MAX_PAYLOAD = cfd_pkg::CFD_MAX_PAYLOAD
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfd_pkg::cfg_t           cfg,
  input  logic                    accept,
  input  logic [7:0]              rx_byte,
  input  logic                    buffer_end,
  output logic                    res_valid,
  output cfd_pkg::result_t        res,
  output cfd_pkg::parser_status_t status
);
  import cfd_pkg::*;

  localparam int IDX_W = $clog2(MAX_PAYLOAD + HDR_BYTES + 3);
  localparam logic [IDX_W-1:0] HDR_IDX  = IDX_W'(HDR_BYTES);
  localparam logic [IDX_W-1:0] LAST_HDR = HDR_IDX - 1'b1;
  localparam logic [IDX_W-1:0] ERR_IDX  = HDR_IDX + 1'b1;

  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [15:0]      crc_acc, crc_acc_next;
  logic [31:0]      magic_seen, magic_seen_next;
  logic [7:0]       version_seen, version_seen_next;
  logic [7:0]       kind_seen, kind_seen_next;
  logic [15:0]      length_seen, length_seen_next;
  logic [31:0]      sequence_seen, sequence_seen_next;
  logic [15:0]      crc_seen, crc_seen_next;
  verdict_t         pending_error, pending_error_next;
  logic             verdict_given, verdict_given_next;

  logic [15:0]      crc_seed;
  logic [15:0]      crc_upd;
  logic [IDX_W-1:0] payload_end;

  function automatic result_t make_verdict(verdict_t code, logic [7:0] kind,
                                           logic [31:0] seq, logic [15:0] len,
                                           logic [15:0] crc);
    result_t r;
    r                 = '0;
    r.item_kind       = KIND_VERDICT;
    r.verdict         = code;
    r.frame_kind      = kind;
    r.sequence_number = seq;
    r.payload_count   = (len > 16'(COUNT_SAT)) ? COUNT_SAT : len[10:0];
    r.received_crc    = crc;
    return r;
  endfunction

  assign crc_seed    = (byte_index == '0) ? cfg.crc_start : crc_acc;
  assign crc_upd     = crc16_byte(crc_seed, rx_byte);
  assign payload_end = HDR_IDX + IDX_W'(length_seen);

  always_comb begin
    byte_index_next    = byte_index;
    crc_acc_next       = crc_acc;
    magic_seen_next    = magic_seen;
    version_seen_next  = version_seen;
    kind_seen_next     = kind_seen;
    length_seen_next   = length_seen;
    sequence_seen_next = sequence_seen;
    crc_seen_next      = crc_seen;
    pending_error_next = pending_error;
    verdict_given_next = verdict_given;
    res_valid          = 1'b0;
    res                = '0;

    if (!verdict_given) begin
      if (byte_index < HDR_IDX) begin
        crc_acc_next = crc_upd;
        case (byte_index[3:0])
          4'd0:    magic_seen_next[7:0]      = rx_byte;
          4'd1:    magic_seen_next[15:8]     = rx_byte;
          4'd2:    magic_seen_next[23:16]    = rx_byte;
          4'd3:    magic_seen_next[31:24]    = rx_byte;
          4'd4:    version_seen_next         = rx_byte;
          4'd5:    kind_seen_next            = rx_byte;
          4'd6:    length_seen_next[7:0]     = rx_byte;
          4'd7:    length_seen_next[15:8]    = rx_byte;
          4'd8:    sequence_seen_next[7:0]   = rx_byte;
          4'd9:    sequence_seen_next[15:8]  = rx_byte;
          4'd10:   sequence_seen_next[23:16] = rx_byte;
          4'd11:   sequence_seen_next[31:24] = rx_byte;
          default: ;
        endcase
        if (byte_index == LAST_HDR) begin
          if (magic_seen_next != cfg.magic_word)
            pending_error_next = VERDICT_BAD_MAGIC;
          else if (version_seen_next != cfg.version_byte)
            pending_error_next = VERDICT_BAD_VERSION;
          else if (length_seen_next > 16'(MAX_PAYLOAD))
            pending_error_next = VERDICT_TOO_LONG;
        end
        if (buffer_end) begin
          res_valid = 1'b1;
          res = make_verdict(VERDICT_TOO_SHORT, kind_seen_next, sequence_seen_next,
                             length_seen_next, crc_seen);
        end
      end else if (pending_error != VERDICT_OK) begin
        if (byte_index == ERR_IDX) begin
          res_valid = 1'b1;
          res = make_verdict(pending_error, kind_seen, sequence_seen, length_seen, crc_seen);
        end else if (buffer_end) begin
          res_valid = 1'b1;
          res = make_verdict(VERDICT_TOO_SHORT, kind_seen, sequence_seen, length_seen,
                             crc_seen);
        end
      end else if (byte_index < payload_end) begin
        crc_acc_next = crc_upd;
        res_valid    = 1'b1;
        if (buffer_end) begin
          res = make_verdict(VERDICT_TOO_SHORT, kind_seen, sequence_seen, length_seen,
                             crc_seen);
        end else begin
          res.item_kind    = KIND_PAYLOAD;
          res.payload_byte = rx_byte;
        end
      end else if (byte_index == payload_end) begin
        crc_seen_next = {8'h00, rx_byte};
        if (buffer_end) begin
          res_valid = 1'b1;
          res = make_verdict(VERDICT_TOO_SHORT, kind_seen, sequence_seen, length_seen,
                             crc_seen_next);
        end
      end else begin
        crc_seen_next = {rx_byte, crc_seen[7:0]};
        res_valid     = 1'b1;
        res = make_verdict((crc_seen_next == crc_acc) ? VERDICT_OK : VERDICT_BAD_CRC,
                           kind_seen, sequence_seen, length_seen, crc_seen_next);
      end

      if (res_valid && (res.item_kind == KIND_VERDICT))
        verdict_given_next = 1'b1;
      else
        byte_index_next = byte_index + 1'b1;
    end

    if (buffer_end) begin
      byte_index_next    = '0;
      crc_acc_next       = cfg.crc_start;
      magic_seen_next    = '0;
      version_seen_next  = '0;
      kind_seen_next     = '0;
      length_seen_next   = '0;
      sequence_seen_next = '0;
      crc_seen_next      = '0;
      pending_error_next = VERDICT_OK;
      verdict_given_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      crc_acc       <= 16'hFFFF;
      magic_seen    <= '0;
      version_seen  <= '0;
      kind_seen     <= '0;
      length_seen   <= '0;
      sequence_seen <= '0;
      crc_seen      <= '0;
      pending_error <= VERDICT_OK;
      verdict_given <= 1'b0;
    end else if (accept) begin
      byte_index    <= byte_index_next;
      crc_acc       <= crc_acc_next;
      magic_seen    <= magic_seen_next;
      version_seen  <= version_seen_next;
      kind_seen     <= kind_seen_next;
      length_seen   <= length_seen_next;
      sequence_seen <= sequence_seen_next;
      crc_seen      <= crc_seen_next;
      pending_error <= pending_error_next;
      verdict_given <= verdict_given_next;
    end
  end

  assign status.frame_clear   = (byte_index == '0) && !verdict_given &&
                                (pending_error == VERDICT_OK);
  assign status.verdict_given = verdict_given;

endmodule

@@ rtl/cfd_skid.sv @@
// cfd_skid: two-entry result register, output stage plus skid stage
// depends on cfd_pkg for the result type

module cfd_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cfd_pkg::result_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cfd_pkg::result_t out_data
);
  import cfd_pkg::*;

  result_t main_data;
  result_t skid_data;
  logic    main_valid;
  logic    skid_valid;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_data <= skid_valid ? skid_data : in_data;
    end
    if (main_valid && !out_ready && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

@@ tb/crc16_frame_deframer_tb.sv @@
// crc16_frame_deframer_tb: self-checking testbench for the crc-16 frame deframer
// depends on cfd_pkg, cfd_if and the deframer rtl; predicts every result and compares in order
// directed: reset values, header errors, short buffers, crc, max frame; then random traffic

module crc16_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfd_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfd_rx_if rx_ch ();
  cfd_tx_if tx_ch ();

  crc16_frame_deframer uut (
    .clk       (clk),
    .rst       (rst),
    .rx_ch     (rx_ch),
    .tx_ch     (tx_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // configuration as the deframer holds it
  logic [31:0] cfg_magic   = 32'h0;
  logic [7:0]  cfg_version = 8'h00;
  logic [15:0] cfg_seed    = 16'hFFFF;

  // frame tracking state
  int          frame_pos    = 0;
  logic [15:0] crc_run      = 16'hFFFF;
  logic [31:0] hdr_magic    = 32'h0;
  logic [7:0]  hdr_version  = 8'h00;
  logic [7:0]  hdr_kind     = 8'h00;
  logic [15:0] hdr_length   = 16'h0;
  logic [31:0] hdr_seq      = 32'h0;
  logic [15:0] trail_crc    = 16'h0;
  verdict_t    held_error   = VERDICT_OK;
  bit          verdict_done = 1'b0;

  result_t     pending_results[$];
  logic [7:0]  frame_bytes[$];

  int send_idle     = 33;
  int recv_idle     = 76;
  int error_count   = 0;
  int bytes_sent    = 0;
  int buffers_sent  = 0;
  int results_seen  = 0;
  int stall_cycles  = 0;
  int verdict_tally[6];

  always #5 clk = ~clk;

  always @(posedge clk) tx_ch.ready <= ($urandom_range(99) >= recv_idle);

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ data[k];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void append_result(input result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void append_byte(input logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endfunction

  task automatic start_new_frame();
    frame_pos    = 0;
    crc_run      = cfg_seed;
    hdr_magic    = 32'h0;
    hdr_version  = 8'h00;
    hdr_kind     = 8'h00;
    hdr_length   = 16'h0;
    hdr_seq      = 32'h0;
    trail_crc    = 16'h0;
    held_error   = VERDICT_OK;
    verdict_done = 1'b0;
  endtask

  task automatic push_verdict(input verdict_t code);
    result_t r;
    r                 = '0;
    r.item_kind       = KIND_VERDICT;
    r.verdict         = code;
    r.frame_kind      = hdr_kind;
    r.sequence_number = hdr_seq;
    r.payload_count   = (hdr_length > 16'd2047) ? COUNT_SAT : hdr_length[10:0];
    r.received_crc    = trail_crc;
    append_result(r);
    verdict_tally[code]++;
    verdict_done = 1'b1;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    result_t     r;
    logic [15:0] seed;
    seed = (frame_pos == 0) ? cfg_seed : crc_run;
    if (!verdict_done) begin
      if (frame_pos < HDR_BYTES) begin
        crc_run = crc_step(seed, b);
        case (frame_pos)
          0, 1, 2, 3: hdr_magic[8*frame_pos +: 8] = b;
          4: hdr_version = b;
          5: hdr_kind = b;
          6, 7: hdr_length[8*(frame_pos-6) +: 8] = b;
          default: hdr_seq[8*(frame_pos-8) +: 8] = b;
        endcase
        if (frame_pos == HDR_BYTES - 1) begin
          if (hdr_magic != cfg_magic) begin
            held_error = VERDICT_BAD_MAGIC;
          end else if (hdr_version != cfg_version) begin
            held_error = VERDICT_BAD_VERSION;
          end else if (hdr_length > CFD_MAX_PAYLOAD) begin
            held_error = VERDICT_TOO_LONG;
          end
        end
        if (last) push_verdict(VERDICT_TOO_SHORT);
      end else if (held_error != VERDICT_OK) begin
        if (frame_pos == HDR_BYTES + 1) begin
          push_verdict(held_error);
        end else if (last) begin
          push_verdict(VERDICT_TOO_SHORT);
        end
      end else if (frame_pos < HDR_BYTES + hdr_length) begin
        crc_run = crc_step(seed, b);
        if (last) begin
          push_verdict(VERDICT_TOO_SHORT);
        end else begin
          r              = '0;
          r.item_kind    = KIND_PAYLOAD;
          r.payload_byte = b;
          append_result(r);
        end
      end else if (frame_pos == HDR_BYTES + hdr_length) begin
        trail_crc = {8'h00, b};
        if (last) push_verdict(VERDICT_TOO_SHORT);
      end else begin
        trail_crc[15:8] = b;
        push_verdict((trail_crc == crc_run) ? VERDICT_OK : VERDICT_BAD_CRC);
      end
      if (!verdict_done) frame_pos++;
    end
    if (last) start_new_frame();
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle) begin
      rx_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    rx_ch.valid      <= 1'b1;
    rx_ch.rx_byte    <= b;
    rx_ch.buffer_end <= last;
    do @(posedge clk); while (!rx_ch.ready);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    buffers_sent++;
  endtask

  // header, body_n payload bytes, crc, trail_n extra bytes; cut > 0 keeps only the first cut bytes
  task automatic send_frame(input logic [31:0] magic, input logic [7:0] version,
                            input logic [7:0] kind, input logic [15:0] len_field,
                            input logic [31:0] seq, input int body_n, input bit crc_bad,
                            input int trail_n, input int cut);
    logic [15:0] crc;
    frame_bytes.delete();
    for (int i = 0; i < 4; i++) append_byte(magic[8*i +: 8]);
    append_byte(version);
    append_byte(kind);
    append_byte(len_field[7:0]);
    append_byte(len_field[15:8]);
    for (int i = 0; i < 4; i++) append_byte(seq[8*i +: 8]);
    for (int i = 0; i < body_n; i++) append_byte(8'($urandom));
    crc = cfg_seed;
    foreach (frame_bytes[i]) crc = crc_step(crc, frame_bytes[i]);
    if (crc_bad) crc = crc ^ 16'($urandom_range(65535, 1));
    append_byte(crc[7:0]);
    append_byte(crc[15:8]);
    for (int i = 0; i < trail_n; i++) append_byte(8'($urandom));
    if (cut > 0 && cut < frame_bytes.size()) frame_bytes = frame_bytes[0:cut-1];
    send_buffer();
  endtask

  task automatic wait_drain();
    rx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_config(input logic [31:0] magic, input logic [7:0] version,
                              input logic [15:0] seed);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAGIC;
    cfg_data  <= magic;
    @(posedge clk);
    cfg_magic = magic;
    cfg_index <= CFG_VERSION;
    cfg_data  <= {24'h0, version};
    @(posedge clk);
    cfg_version = version;
    cfg_index <= CFG_CRC_START;
    cfg_data  <= {16'h0, seed};
    @(posedge clk);
    cfg_seed = seed;
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result expected none actual kind %0b byte %0h verdict %0d", $time,
                 tx_ch.item_kind, tx_ch.payload_byte, tx_ch.verdict);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("item_kind", want.item_kind, tx_ch.item_kind);
        check_field("payload_byte", want.payload_byte, tx_ch.payload_byte);
        check_field("verdict", want.verdict, tx_ch.verdict);
        check_field("frame_kind", want.frame_kind, tx_ch.frame_kind);
        check_field("sequence_number", want.sequence_number, tx_ch.sequence_number);
        check_field("payload_count", want.payload_count, tx_ch.payload_count);
        check_field("received_crc", want.received_crc, tx_ch.received_crc);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, stall_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // reset values: magic 0, version 0, seed ffff
  task automatic test_reset_defaults();
    send_frame(32'h0, 8'h00, 8'h00, 16'd0, 32'h0, 0, 1'b0, 0, 0);
    send_frame(32'h0, 8'h00, 8'hFF, 16'd2, 32'hFFFF_FFFF, 2, 1'b0, 2, 0);
  endtask

  task automatic test_header_checks();
    apply_config(32'hFFFF_FFFF, 8'hFF, 16'h0000);
    send_frame(cfg_magic ^ 32'h8000_0000, cfg_version, 8'($urandom), 16'd4, $urandom, 4,
               1'b0, 0, 0);
    send_frame(cfg_magic ^ 32'h1, cfg_version ^ 8'h01, 8'($urandom), 16'd1025, $urandom, 3,
               1'b0, 0, 0);
    send_frame(cfg_magic, cfg_version ^ 8'h80, 8'($urandom), 16'd1025, $urandom, 2,
               1'b0, 0, 0);
    send_frame(cfg_magic, cfg_version, 8'($urandom), 16'd1025, $urandom, 2, 1'b0, 0, 0);
    send_frame(cfg_magic, cfg_version, 8'($urandom), 16'hFFFF, $urandom, 3, 1'b0, 1, 0);
  endtask

  task automatic test_short_buffers();
    send_frame(cfg_magic, cfg_version, 8'($urandom), 16'd4, $urandom, 4, 1'b0, 0, 1);
    send_frame(cfg_magic, cfg_version, 8'($urandom), 16'd4, $urandom, 4, 1'b0, 0, 12);
    send_frame(cfg_magic ^ 32'h100, cfg_version, 8'($urandom), 16'd4, $urandom, 4,
               1'b0, 0, 12);
    send_frame(cfg_magic ^ 32'h100, cfg_version, 8'($urandom), 16'd4, $urandom, 4,
               1'b0, 0, 13);
    send_frame(cfg_magic ^ 32'h100, cfg_version, 8'($urandom), 16'd4, $urandom, 4,
               1'b0, 0, 14);
    send_frame(cfg_magic, cfg_version, 8'($urandom), 16'd5, $urandom, 5, 1'b0, 0, 15);
    send_frame(cfg_magic, cfg_version, 8'($urandom), 16'd2, $urandom, 2, 1'b0, 0, 15);
  endtask

  task automatic test_crc_checks();
    apply_config($urandom, 8'h00, 16'($urandom));
    send_frame(cfg_magic, cfg_version, 8'($urandom), 16'd3, $urandom, 3, 1'b1, 0, 0);
    send_frame(cfg_magic, cfg_version, 8'($urandom), 16'd0, $urandom, 0, 1'b1, 0, 0);
    send_frame(cfg_magic, cfg_version, 8'($urandom), 16'd1, $urandom, 1, 1'b0, 3, 0);
  endtask

  task automatic test_longest_frame();
    apply_config($urandom, 8'($urandom), 16'hFFFF);
    send_frame(cfg_magic, cfg_version, 8'($urandom), 16'(CFD_MAX_PAYLOAD), $urandom,
               40, 1'b0, 0, 40);
  endtask

  task automatic test_random_traffic(input int src_idle, input int dst_idle, input int n_bytes);
    int first;
    int pick;
    int len;
    int trail;
    send_idle = src_idle;
    recv_idle = dst_idle;
    apply_config($urandom, 8'($urandom), 16'($urandom));
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      pick  = $urandom_range(99);
      len   = ($urandom_range(99) < 5) ? $urandom_range(64, 11) : $urandom_range(10, 0);
      trail = ($urandom_range(99) < 20) ? $urandom_range(3, 1) : 0;
      if (pick < 60) begin
        send_frame(cfg_magic, cfg_version, 8'($urandom), 16'(len), $urandom, len,
                   1'b0, trail, 0);
      end else if (pick < 68) begin
        send_frame(cfg_magic, cfg_version, 8'($urandom), 16'(len), $urandom, len,
                   1'b1, trail, 0);
      end else if (pick < 72) begin
        send_frame(cfg_magic ^ (32'h1 << $urandom_range(31)), cfg_version, 8'($urandom),
                   16'(len), $urandom, len, 1'b0, trail, 0);
      end else if (pick < 76) begin
        send_frame(cfg_magic, cfg_version ^ (8'h1 << $urandom_range(7)), 8'($urandom),
                   16'(len), $urandom, len, 1'b0, trail, 0);
      end else if (pick < 80) begin
        send_frame(cfg_magic, cfg_version, 8'($urandom), 16'($urandom_range(65535, 1025)),
                   $urandom, len, 1'b0, trail, 0);
      end else if (pick < 92) begin
        send_frame(cfg_magic, cfg_version, 8'($urandom), 16'(len), $urandom, len, 1'b0, 0,
                   $urandom_range(HDR_BYTES + len + 1, 1));
      end else begin
        frame_bytes.delete();
        repeat ($urandom_range(20, 1)) append_byte(8'($urandom));
        send_buffer();
      end
    end
  endtask

  initial begin
    rx_ch.valid      = 1'b0;
    rx_ch.rx_byte    = 8'h00;
    rx_ch.buffer_end = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_MAGIC;
    cfg_data         = '0;
    foreach (verdict_tally[i]) verdict_tally[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_header_checks();
    test_short_buffers();
    test_crc_checks();
    test_longest_frame();
    test_random_traffic(33, 76, 40);
    test_random_traffic(76, 33, 40);
    test_random_traffic(0, 0, 40);
    wait_drain();

    $display("%0d bytes in %0d buffers sent, %0d results checked", bytes_sent, buffers_sent,
             results_seen);
    $display("verdicts: ok %0d, too short %0d, bad magic %0d, bad version %0d, %s %0d, %s %0d",
             verdict_tally[VERDICT_OK], verdict_tally[VERDICT_TOO_SHORT],
             verdict_tally[VERDICT_BAD_MAGIC], verdict_tally[VERDICT_BAD_VERSION],
             "too long", verdict_tally[VERDICT_TOO_LONG],
             "bad crc", verdict_tally[VERDICT_BAD_CRC]);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cfd_pkg.sv
rtl/cfd_if.sv
rtl/cfd_parser.sv
rtl/cfd_skid.sv
rtl/crc16_frame_deframer.sv
tb/crc16_frame_deframer_tb.sv
